[rtl/mffd_pkg.sv]
// ----------------------------------------------------------------------------
// Motor feedback frame decoder package
// Register indexes, field codes, scaling constants and the constant-divide
// helper shared by the decoder core.
// ----------------------------------------------------------------------------
package mffd_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_MOTOR_ID   = 2'd0;
  localparam logic [1:0] CFG_HOST_ID    = 2'd1;
  localparam logic [1:0] CFG_POS_PROF   = 2'd2;

  // Register reset values
  localparam logic [7:0] MOTOR_ID_RST   = 8'd1;
  localparam logic [7:0] HOST_ID_RST    = 8'd0;
  localparam logic [1:0] POS_PROF_RST   = 2'd0;

  // Position profile codes (anything else rejects every frame)
  localparam logic [1:0] PROF_4PI       = 2'd0;
  localparam logic [1:0] PROF_12P5      = 2'd1;

  // Frame format constants
  localparam logic [4:0] FEEDBACK_TYPE_DEF = 5'd2;
  localparam logic [3:0] FRAME_LEN_FULL    = 4'd8;
  localparam logic [7:0] MOTOR_ID_MIN      = 8'd1;
  localparam logic [7:0] MOTOR_ID_MAX      = 8'd126;
  localparam logic [1:0] MODE_MAX          = 2'd2;
  localparam logic [1:0] MODE_ENABLED      = 2'd2;
  localparam logic [15:0] TEMP_MAX         = 16'd2000;

  // Q16 span and low-bound magnitude of each quantity (span = 2 * magnitude)
  localparam logic [21:0] POS0_MAG  = 22'd823550;
  localparam logic [21:0] POS0_SPAN = 22'd1647100;
  localparam logic [21:0] POS1_MAG  = 22'd819200;
  localparam logic [21:0] POS1_SPAN = 22'd1638400;
  localparam logic [21:0] VEL_MAG   = 22'd1966080;
  localparam logic [21:0] VEL_SPAN  = 22'd3932160;
  localparam logic [21:0] TRQ_MAG   = 22'd786432;
  localparam logic [21:0] TRQ_SPAN  = 22'd1572864;

  // floor(p / 65535) for p below 2^38: p = a*65535 + (a+b), then fold once more
  function automatic logic [21:0] div65535(input logic [37:0] p);
    logic [21:0] a;
    logic [22:0] c;
    logic [6:0]  c1;
    logic [16:0] s;
    a  = p[37:16];
    c  = {1'b0, a} + {7'b0, p[15:0]};
    c1 = c[22:16];
    s  = {1'b0, c[15:0]} + {10'b0, c1};
    return a + {15'b0, c1} + {21'b0, (s >= 17'd65535)};
  endfunction

  // lo + floor(raw * span / 65535), lo = -mag; result in 23-bit two's complement
  function automatic logic [22:0] unmap_q16(input logic [15:0] raw,
                                            input logic [21:0] span,
                                            input logic [21:0] mag);
    logic [37:0] prod;
    logic [21:0] q;
    prod = {22'b0, raw} * {16'b0, span};
    q    = div65535(prod);
    return {1'b0, q} - {1'b0, mag};
  endfunction

endpackage

[rtl/motor_feedback_frame_decoder_core.sv]
// ----------------------------------------------------------------------------
// Motor feedback frame decoder core
// Checks one received CAN frame per cycle as a motor feedback frame and
// unpacks position, velocity, torque, temperature, faults and mode.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: a frame transfers on a rising edge with start high and
//   busy low. busy stays low, so a frame may be offered in every cycle.
//   Result channel: out_valid is high for exactly one cycle per frame, once
//   the frame has passed the input and result registers; the receiver cannot stall it.
//   A frame passes the input register, then decode/scale into the result
//   register; throughput is one frame per cycle, since the whole decode is
//   one pass of logic between the two registers: one 16x22 constant-span
//   multiply per quantity and the fold-add divide by 65535.
//   out_status = 1 marks a rejected frame; all other result fields are 0.
//   Configuration: cfg_we writes cfg_wdata to register cfg_index
//   (0 motor id, 1 host id, 2 position profile); index 3 is ignored.
//   Write registers only while no frame is in flight.
//   Reset (rst_n low, synchronous) clears the pipeline valid bits and loads
//   motor id 1, host id 0 and position profile 0.
// ----------------------------------------------------------------------------
module motor_feedback_frame_decoder_core
  import mffd_pkg::*;
#(
  parameter logic [4:0] FEEDBACK_TYPE_CODE = FEEDBACK_TYPE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration port
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_wdata,
  // input channel
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        in_frame_id,
  input  logic [3:0]         in_frame_length,
  input  logic               in_is_extended,
  input  logic               in_is_remote,
  input  logic [63:0]        in_payload,
  input  logic [31:0]        in_rx_tick,
  // result channel
  output logic               out_valid,
  output logic               out_status,
  output logic signed [20:0] out_position_q16,
  output logic signed [21:0] out_velocity_q16,
  output logic signed [20:0] out_torque_q16,
  output logic [10:0]        out_temperature_tenths,
  output logic [5:0]         out_fault_bits,
  output logic [1:0]         out_run_mode,
  output logic               out_is_enabled,
  output logic               out_is_online,
  output logic [31:0]        out_last_tick
);

  // configuration registers
  logic [7:0] motor_id_r;
  logic [7:0] host_id_r;
  logic [1:0] pos_prof_r;

  // input stage
  logic        s1_valid_r;
  logic [31:0] s1_id_r;
  logic [3:0]  s1_len_r;
  logic        s1_ext_r;
  logic        s1_rem_r;
  logic [63:0] s1_pl_r;
  logic [31:0] s1_tick_r;

  // result stage
  logic        out_valid_r;
  logic        status_r;
  logic [20:0] pos_r;
  logic [21:0] vel_r;
  logic [20:0] trq_r;
  logic [10:0] temp_r;
  logic [5:0]  fault_r;
  logic [1:0]  mode_r;
  logic        enabled_r;
  logic        online_r;
  logic [31:0] tick_r;

  // decode stage next values
  logic        status_nxt;
  logic [20:0] pos_nxt;
  logic [21:0] vel_nxt;
  logic [20:0] trq_nxt;
  logic [10:0] temp_nxt;
  logic [5:0]  fault_nxt;
  logic [1:0]  mode_nxt;
  logic        enabled_nxt;
  logic        online_nxt;
  logic [31:0] tick_nxt;

  logic        in_xfer;

  assign busy    = 1'b0;
  assign in_xfer = start & ~busy;

  // write configuration registers; unknown index is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motor_id_r <= MOTOR_ID_RST;
      host_id_r  <= HOST_ID_RST;
      pos_prof_r <= POS_PROF_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MOTOR_ID: motor_id_r <= cfg_wdata;
        CFG_HOST_ID:  host_id_r  <= cfg_wdata;
        CFG_POS_PROF: pos_prof_r <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // capture the frame on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_id_r   <= in_frame_id;
      s1_len_r  <= in_frame_length;
      s1_ext_r  <= in_is_extended;
      s1_rem_r  <= in_is_remote;
      s1_pl_r   <= in_payload;
      s1_tick_r <= in_rx_tick;
    end
  end

  // check the frame and scale the raw values
  always_comb begin
    logic        ok;
    logic [1:0]  mode;
    logic [15:0] temp;
    logic [21:0] pspan;
    logic [21:0] pmag;
    logic [22:0] pos_full;
    logic [22:0] vel_full;
    logic [22:0] trq_full;
    mode = s1_id_r[23:22];
    temp = s1_pl_r[15:0];
    ok = 1'b1;
    if (motor_id_r < MOTOR_ID_MIN || motor_id_r > MOTOR_ID_MAX) ok = 1'b0;
    if (pos_prof_r != PROF_4PI && pos_prof_r != PROF_12P5) ok = 1'b0;
    if (s1_len_r != FRAME_LEN_FULL || !s1_ext_r || s1_rem_r) ok = 1'b0;
    if (s1_id_r[31:29] != 3'b000) ok = 1'b0;
    if (s1_id_r[28:24] != FEEDBACK_TYPE_CODE) ok = 1'b0;
    if (s1_id_r[7:0] != host_id_r || s1_id_r[15:8] != motor_id_r) ok = 1'b0;
    if (mode > MODE_MAX || temp > TEMP_MAX) ok = 1'b0;

    pspan = (pos_prof_r == PROF_4PI) ? POS0_SPAN : POS1_SPAN;
    pmag  = (pos_prof_r == PROF_4PI) ? POS0_MAG  : POS1_MAG;
    pos_full = unmap_q16(s1_pl_r[63:48], pspan, pmag);
    vel_full = unmap_q16(s1_pl_r[47:32], VEL_SPAN, VEL_MAG);
    trq_full = unmap_q16(s1_pl_r[31:16], TRQ_SPAN, TRQ_MAG);

    status_nxt  = ~ok;
    pos_nxt     = ok ? pos_full[20:0] : '0;
    vel_nxt     = ok ? vel_full[21:0] : '0;
    trq_nxt     = ok ? trq_full[20:0] : '0;
    temp_nxt    = ok ? temp[10:0] : '0;
    fault_nxt   = ok ? s1_id_r[21:16] : '0;
    mode_nxt    = ok ? mode : '0;
    enabled_nxt = ok && (mode == MODE_ENABLED);
    online_nxt  = ok;
    tick_nxt    = ok ? s1_tick_r : '0;
  end

  // advance into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      status_r  <= status_nxt;
      pos_r     <= pos_nxt;
      vel_r     <= vel_nxt;
      trq_r     <= trq_nxt;
      temp_r    <= temp_nxt;
      fault_r   <= fault_nxt;
      mode_r    <= mode_nxt;
      enabled_r <= enabled_nxt;
      online_r  <= online_nxt;
      tick_r    <= tick_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_status             = status_r;
  assign out_position_q16       = pos_r;
  assign out_velocity_q16       = vel_r;
  assign out_torque_q16         = trq_r;
  assign out_temperature_tenths = temp_r;
  assign out_fault_bits         = fault_r;
  assign out_run_mode           = mode_r;
  assign out_is_enabled         = enabled_r;
  assign out_is_online          = online_r;
  assign out_last_tick          = tick_r;

  // every frame captured in the input register gives exactly one result in the result register
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |=> out_valid)
    else $error("result strobe missing after captured frame");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |=> !out_valid)
    else $error("result strobe without captured frame");

  // a rejected frame carries only the status bit
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_position_q16 == '0 && out_velocity_q16 == '0
      && out_torque_q16 == '0 && out_temperature_tenths == '0 && out_fault_bits == '0
      && out_run_mode == '0 && !out_is_enabled && !out_is_online && out_last_tick == '0))
    else $error("rejected result has nonzero fields");

  // an accepted frame is online with a legal mode and temperature
  a_accept_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_status) |-> (out_is_online && out_run_mode <= MODE_MAX
      && {5'b0, out_temperature_tenths} <= TEMP_MAX
      && out_is_enabled == (out_run_mode == MODE_ENABLED)))
    else $error("accepted result fields inconsistent");

endmodule
